// ===== rtl/i2cme_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// i2cme_pkg
// Shared types and constants for the I2C master byte engine: command codes,
// configuration register indexes, sequencer states and the result record.
// ----------------------------------------------------------------------------
package i2cme_pkg;

  // configuration registers
  localparam int CfgIndexW  = 1;
  localparam int CfgDataW   = 16;
  localparam int PhaseW     = 16;
  localparam int TimeoutW   = 8;

  localparam logic [CfgIndexW-1:0] CFG_PHASE_TICKS = 1'b0;
  localparam logic [CfgIndexW-1:0] CFG_ACK_TIMEOUT = 1'b1;

  localparam logic [PhaseW-1:0]   PHASE_TICKS_RST = 16'd320;
  localparam logic [TimeoutW-1:0] ACK_TIMEOUT_RST = 8'd200;

  localparam int BitCntW = 4;
  localparam logic [BitCntW-1:0] BITS_PER_BYTE = 4'd8;

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_STOP  = 2'd1,
    OP_WRITE = 2'd2,
    OP_READ  = 2'd3
  } op_t;

  // bus sequencer phases
  typedef enum logic [18:0] {
    ST_IDLE   = 19'h00001,
    ST_S_A    = 19'h00002,
    ST_S_B    = 19'h00004,
    ST_S_C    = 19'h00008,
    ST_S_D    = 19'h00010,
    ST_P_A    = 19'h00020,
    ST_P_B    = 19'h00040,
    ST_P_C    = 19'h00080,
    ST_W_DATA = 19'h00100,
    ST_W_HIGH = 19'h00200,
    ST_W_LOW  = 19'h00400,
    ST_W_REL  = 19'h00800,
    ST_W_POLL = 19'h01000,
    ST_W_TAIL = 19'h02000,
    ST_R_REL  = 19'h04000,
    ST_R_HIGH = 19'h08000,
    ST_R_HOLD = 19'h10000,
    ST_R_LOW  = 19'h20000,
    ST_R_ACK  = 19'h40000
  } state_t;

  typedef struct packed {
    logic       scl;
    logic       sda_drive;
    logic       sda_output_enable;
    logic       busy_res;
    logic       done_res;
    logic       ack_received;
    logic [7:0] read_byte;
  } result_t;

endpackage
`default_nettype wire

// ===== rtl/i2cme_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// i2cme_core
// Bus phase sequencer. Holds the engine state and configuration registers and
// computes the updated line levels and flags for the tick being accepted.
// ----------------------------------------------------------------------------
module i2cme_core (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             accept,
  input  wire logic                             cmd_valid,
  input  wire logic [1:0]                       operation,
  input  wire logic [7:0]                       write_byte,
  input  wire logic                             send_ack,
  input  wire logic                             sda_in,
  input  wire logic                             cfg_write,
  input  wire logic [i2cme_pkg::CfgIndexW-1:0]  cfg_index,
  input  wire logic [i2cme_pkg::CfgDataW-1:0]   cfg_data,
  output i2cme_pkg::result_t                    res
);

  logic [i2cme_pkg::PhaseW-1:0]   phase_ticks;
  logic [i2cme_pkg::TimeoutW-1:0] ack_timeout;

  i2cme_pkg::state_t             st, st_next, tgt;
  logic [i2cme_pkg::BitCntW-1:0] bit_cnt, bit_cnt_next;
  logic [7:0]                    shreg, shreg_next;
  logic [i2cme_pkg::PhaseW-1:0]  pcnt, pcnt_next;
  logic [i2cme_pkg::TimeoutW-1:0] ack_wait, ack_wait_next;
  logic                          ack_flag, ack_flag_next;
  logic                          want_ack, want_ack_next;
  logic                          scl, scl_next;
  logic                          sda, sda_next;
  logic                          sda_oe, sda_oe_next;
  logic [7:0]                    last_read, last_read_next;

  logic [i2cme_pkg::PhaseW-1:0]  plen;
  logic                          in_phase;
  logic                          enter;
  logic                          finish;
  logic [i2cme_pkg::BitCntW-1:0] bit_inc;

  // a phase length of zero behaves as one tick
  assign plen     = (phase_ticks == '0) ? {{(i2cme_pkg::PhaseW-1){1'b0}}, 1'b1} : phase_ticks;
  assign in_phase = pcnt < plen;
  assign bit_inc  = bit_cnt + {{(i2cme_pkg::BitCntW-1){1'b0}}, 1'b1};

  always_comb begin
    st_next        = st;
    bit_cnt_next   = bit_cnt;
    shreg_next     = shreg;
    pcnt_next      = pcnt;
    ack_wait_next  = ack_wait;
    ack_flag_next  = ack_flag;
    want_ack_next  = want_ack;
    scl_next       = scl;
    sda_next       = sda;
    sda_oe_next    = sda_oe;
    last_read_next = last_read;
    tgt            = i2cme_pkg::ST_IDLE;
    enter          = 1'b0;
    finish         = 1'b0;

    case (st)
      i2cme_pkg::ST_IDLE: begin
        if (cmd_valid) begin
          enter = 1'b1;
          case (i2cme_pkg::op_t'(operation))
            i2cme_pkg::OP_START: tgt = i2cme_pkg::ST_S_A;
            i2cme_pkg::OP_STOP:  tgt = i2cme_pkg::ST_P_A;
            i2cme_pkg::OP_WRITE: begin
              shreg_next   = write_byte;
              bit_cnt_next = '0;
              tgt          = i2cme_pkg::ST_W_DATA;
            end
            default: begin
              shreg_next    = '0;
              bit_cnt_next  = '0;
              want_ack_next = send_ack;
              tgt           = i2cme_pkg::ST_R_REL;
            end
          endcase
        end
      end
      i2cme_pkg::ST_W_POLL: begin
        if (!sda_in) begin
          ack_flag_next = 1'b1;
          tgt           = i2cme_pkg::ST_W_TAIL;
          enter         = 1'b1;
        end else if (ack_wait >= ack_timeout) begin
          ack_flag_next = 1'b0;
          tgt           = i2cme_pkg::ST_W_TAIL;
          enter         = 1'b1;
        end else begin
          ack_wait_next = ack_wait + {{(i2cme_pkg::TimeoutW-1){1'b0}}, 1'b1};
        end
      end
      i2cme_pkg::ST_S_D, i2cme_pkg::ST_P_C, i2cme_pkg::ST_W_TAIL: begin
        if (in_phase) begin
          pcnt_next = pcnt + {{(i2cme_pkg::PhaseW-1){1'b0}}, 1'b1};
        end else begin
          finish = 1'b1;
        end
      end
      i2cme_pkg::ST_S_A, i2cme_pkg::ST_S_B, i2cme_pkg::ST_S_C,
      i2cme_pkg::ST_P_A, i2cme_pkg::ST_P_B,
      i2cme_pkg::ST_W_DATA, i2cme_pkg::ST_W_HIGH, i2cme_pkg::ST_W_LOW, i2cme_pkg::ST_W_REL,
      i2cme_pkg::ST_R_REL, i2cme_pkg::ST_R_HIGH, i2cme_pkg::ST_R_HOLD, i2cme_pkg::ST_R_LOW,
      i2cme_pkg::ST_R_ACK: begin
        if (in_phase) begin
          pcnt_next = pcnt + {{(i2cme_pkg::PhaseW-1){1'b0}}, 1'b1};
        end else begin
          enter = 1'b1;
          case (st)
            i2cme_pkg::ST_S_A:    tgt = i2cme_pkg::ST_S_B;
            i2cme_pkg::ST_S_B:    tgt = i2cme_pkg::ST_S_C;
            i2cme_pkg::ST_S_C:    tgt = i2cme_pkg::ST_S_D;
            i2cme_pkg::ST_P_A:    tgt = i2cme_pkg::ST_P_B;
            i2cme_pkg::ST_P_B:    tgt = i2cme_pkg::ST_P_C;
            i2cme_pkg::ST_W_DATA: tgt = i2cme_pkg::ST_W_HIGH;
            i2cme_pkg::ST_W_HIGH: tgt = i2cme_pkg::ST_W_LOW;
            i2cme_pkg::ST_W_LOW: begin
              shreg_next   = {shreg[6:0], 1'b0};
              bit_cnt_next = bit_inc;
              tgt = (bit_inc >= i2cme_pkg::BITS_PER_BYTE) ? i2cme_pkg::ST_W_REL
                                                          : i2cme_pkg::ST_W_DATA;
            end
            i2cme_pkg::ST_W_REL:  tgt = i2cme_pkg::ST_W_POLL;
            i2cme_pkg::ST_R_REL:  tgt = i2cme_pkg::ST_R_HIGH;
            i2cme_pkg::ST_R_HIGH: begin
              // sample on the last tick of the high phase
              shreg_next = {shreg[6:0], sda_in};
              tgt        = i2cme_pkg::ST_R_HOLD;
            end
            i2cme_pkg::ST_R_HOLD: tgt = i2cme_pkg::ST_R_LOW;
            i2cme_pkg::ST_R_LOW: begin
              bit_cnt_next = bit_inc;
              tgt = (bit_inc >= i2cme_pkg::BITS_PER_BYTE) ? i2cme_pkg::ST_R_ACK
                                                          : i2cme_pkg::ST_R_HIGH;
            end
            default: begin
              // ack phase over: drop scl and publish the byte
              enter          = 1'b0;
              scl_next       = 1'b0;
              last_read_next = shreg;
              finish         = 1'b1;
            end
          endcase
        end
      end
      default: finish = 1'b1;
    endcase

    if (finish) begin
      st_next   = i2cme_pkg::ST_IDLE;
      pcnt_next = '0;
    end

    if (enter) begin
      st_next   = tgt;
      pcnt_next = {{(i2cme_pkg::PhaseW-1){1'b0}}, 1'b1};
      case (tgt)
        i2cme_pkg::ST_S_A: begin
          sda_oe_next = 1'b1;
          sda_next    = 1'b1;
        end
        i2cme_pkg::ST_S_B: scl_next = 1'b1;
        i2cme_pkg::ST_S_C: sda_next = 1'b0;
        i2cme_pkg::ST_S_D: scl_next = 1'b0;
        i2cme_pkg::ST_P_A: begin
          sda_oe_next = 1'b1;
          sda_next    = 1'b0;
        end
        i2cme_pkg::ST_P_B: scl_next = 1'b1;
        i2cme_pkg::ST_P_C: sda_next = 1'b1;
        i2cme_pkg::ST_W_DATA: begin
          sda_oe_next = 1'b1;
          sda_next    = shreg_next[7];
        end
        i2cme_pkg::ST_W_HIGH: scl_next = 1'b1;
        i2cme_pkg::ST_W_LOW:  scl_next = 1'b0;
        i2cme_pkg::ST_W_REL:  sda_next = 1'b1;
        i2cme_pkg::ST_W_POLL: begin
          sda_oe_next   = 1'b0;
          scl_next      = 1'b1;
          ack_wait_next = '0;
        end
        i2cme_pkg::ST_W_TAIL: scl_next = 1'b0;
        i2cme_pkg::ST_R_REL: begin
          sda_oe_next = 1'b1;
          sda_next    = 1'b1;
        end
        i2cme_pkg::ST_R_HIGH: begin
          sda_oe_next = 1'b0;
          scl_next    = 1'b1;
        end
        i2cme_pkg::ST_R_LOW: scl_next = 1'b0;
        i2cme_pkg::ST_R_ACK: begin
          sda_oe_next = 1'b1;
          sda_next    = ~want_ack_next;
          scl_next    = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    res.scl               = scl_next;
    res.sda_drive         = sda_next;
    res.sda_output_enable = sda_oe_next;
    res.busy_res          = (st_next != i2cme_pkg::ST_IDLE);
    res.done_res          = finish;
    res.ack_received      = ack_flag_next;
    res.read_byte         = last_read_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_ticks <= i2cme_pkg::PHASE_TICKS_RST;
      ack_timeout <= i2cme_pkg::ACK_TIMEOUT_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        i2cme_pkg::CFG_PHASE_TICKS: phase_ticks <= cfg_data;
        i2cme_pkg::CFG_ACK_TIMEOUT: ack_timeout <= cfg_data[i2cme_pkg::TimeoutW-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= i2cme_pkg::ST_IDLE;
      bit_cnt   <= '0;
      shreg     <= '0;
      pcnt      <= '0;
      ack_wait  <= '0;
      ack_flag  <= 1'b0;
      want_ack  <= 1'b0;
      scl       <= 1'b1;
      sda       <= 1'b1;
      sda_oe    <= 1'b0;
      last_read <= '0;
    end else if (accept) begin
      st        <= st_next;
      bit_cnt   <= bit_cnt_next;
      shreg     <= shreg_next;
      pcnt      <= pcnt_next;
      ack_wait  <= ack_wait_next;
      ack_flag  <= ack_flag_next;
      want_ack  <= want_ack_next;
      scl       <= scl_next;
      sda       <= sda_next;
      sda_oe    <= sda_oe_next;
      last_read <= last_read_next;
    end
  end

`ifndef ASSERT_OFF
  // the phase counter runs exactly while a command is in progress
  a_pcnt_busy: assert property (@(posedge clk) disable iff (rst)
    (st == i2cme_pkg::ST_IDLE) == (pcnt == '0))
    else $error("phase counter out of step with sequencer state");

  // state moves only on an accepted tick
  a_hold: assert property (@(posedge clk) disable iff (rst)
    !accept |=> $stable(st) && $stable(pcnt))
    else $error("sequencer advanced without a tick");

  // a completing tick leaves the sequencer idle
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    accept && res.done_res |=> st == i2cme_pkg::ST_IDLE)
    else $error("command completed but sequencer not idle");
`endif

endmodule
`default_nettype wire

// ===== rtl/i2cme_skid.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// i2cme_skid
// Result register with one skid entry. Stall toward the sender comes from a
// flop, so the receiver's stall never reaches the input side combinationally.
// ----------------------------------------------------------------------------
module i2cme_skid (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  input  wire i2cme_pkg::result_t push_data,
  output logic                    full,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output i2cme_pkg::result_t      out_data
);

  logic               skid_valid;
  i2cme_pkg::result_t skid_data;
  logic               take;

  assign take = out_valid && !out_stall;
  assign full = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (take) begin
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (out_valid && !take) begin
        skid_valid <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end else if (take) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (take) begin
        out_data <= skid_data;
      end
    end else if (push) begin
      if (out_valid && !take) begin
        skid_data <= push_data;
      end else begin
        out_data <= push_data;
      end
    end
  end

`ifndef ASSERT_OFF
  a_skid_behind_main: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry held with empty output register");

  a_skid_drains: assert property (@(posedge clk) disable iff (rst)
    skid_valid && !out_stall |=> !skid_valid)
    else $error("skid entry not moved up after a transaction");

  a_skid_fills: assert property (@(posedge clk) disable iff (rst)
    push && out_valid && out_stall && !skid_valid |=> skid_valid && out_valid)
    else $error("result lost while output stalled");
`endif

endmodule
`default_nettype wire

// ===== rtl/i2c_master_byte_engine.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// i2c_master_byte_engine
// I2C master bit sequencer: start, stop, byte write with ack poll, byte read.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall) carries one bus tick per transaction:
//   an optional command plus the sampled SDA level. Commands are taken only
//   when the engine is idle at the start of the tick.
//   Output channel (out_valid/out_stall) returns one result per tick: SCL,
//   SDA drive and enable, busy level, done pulse, ack status, last read byte.
//   An accepted tick's result is registered in the output register, or in
//   the skid entry while the output is stalled; throughput is one tick per
//   cycle while in_stall is low.
//   If the receiver stalls, one further result goes into a skid entry and
//   in_stall rises the cycle after; nothing is dropped or repeated.
//   cfg_write with cfg_index 0 sets ticks per bus phase, index 1 sets the
//   ack timeout; write them only while the engine is idle.
//   Reset (rst, synchronous) leaves core SCL/SDA high with SDA released,
//   the output empty and the registers at 320 ticks and 200 ticks.
// ----------------------------------------------------------------------------
module i2c_master_byte_engine (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic                            cmd_valid,
  input  wire logic [1:0]                      operation,
  input  wire logic [7:0]                      write_byte,
  input  wire logic                            send_ack,
  input  wire logic                            sda_in,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic                                 scl,
  output logic                                 sda_drive,
  output logic                                 sda_output_enable,
  output logic                                 busy_res,
  output logic                                 done_res,
  output logic                                 ack_received,
  output logic [7:0]                           read_byte,
  input  wire logic                            cfg_write,
  input  wire logic [i2cme_pkg::CfgIndexW-1:0] cfg_index,
  input  wire logic [i2cme_pkg::CfgDataW-1:0]  cfg_data
);

  logic               accept;
  logic               full;
  i2cme_pkg::result_t res;
  i2cme_pkg::result_t out_data;

  assign in_stall = full;
  assign accept   = in_valid && !full;

  i2cme_core u_core (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .cmd_valid  (cmd_valid),
    .operation  (operation),
    .write_byte (write_byte),
    .send_ack   (send_ack),
    .sda_in     (sda_in),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .res        (res)
  );

  i2cme_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_data (res),
    .full      (full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  assign scl               = out_data.scl;
  assign sda_drive         = out_data.sda_drive;
  assign sda_output_enable = out_data.sda_output_enable;
  assign busy_res          = out_data.busy_res;
  assign done_res          = out_data.done_res;
  assign ack_received      = out_data.ack_received;
  assign read_byte         = out_data.read_byte;

endmodule
`default_nettype wire
